// File: design/nearest_reference_with_ties_core_macros.svh
// Assertion macros shared by the nearest-reference checker.
`ifndef NEAREST_REFERENCE_WITH_TIES_CORE_MACROS_SVH
`define NEAREST_REFERENCE_WITH_TIES_CORE_MACROS_SVH

// Antecedent in one cycle implies consequent in the next, quiet during reset.
`define NRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nrt check failed");

// Consequent holds in the cycle after reset is seen low.
`define NRT_ASSERT_AFTER_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("nrt reset check failed");

`endif

// File: design/nrt_pkg.sv
// Types and fixed widths of the nearest-reference search block.
package nrt_pkg;

    localparam int COORD_W = 16;   // coordinate field width
    localparam int PT_W    = 17;   // stored coordinate, signed, covers zero-extended input
    localparam int ABS_W   = 16;   // |dx| never exceeds 65535
    localparam int SQ_W    = 32;
    localparam int DIST_W  = 33;
    localparam int QIDX_W  = 32;
    localparam int RIDX_W  = 10;
    localparam int REQ_W   = 2;

    // Request codes on req_type; the fourth code is unused.
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
    } t_req;

    typedef struct packed {
        logic [QIDX_W-1:0] query_index;
        logic [RIDX_W-1:0] ref_index;
        logic [DIST_W-1:0] min_dist;
        logic              last_match;
        logic              tie_overflow;
    } t_result;

    // Classified command passed from front to back.
    typedef struct packed {
        t_cmd_kind              kind;
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
    } t_cmd;

endpackage

// File: design/nrt_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module nrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/nrt_front.sv
// Front end: takes request beats, classifies them and queues commands.
module nrt_front
    import nrt_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    // Shift that sign-extends from bit COORD_BITS-1 inside a PT_W word.
    localparam int SH = (COORD_BITS > COORD_W) ? 1 : PT_W - COORD_BITS;

    function automatic logic signed [PT_W-1:0] f_coord(input logic [COORD_W-1:0] raw);
        logic signed [PT_W-1:0] v;
        v = signed'({1'b0, raw});
        if (COORD_BITS > COORD_W) begin
            return v;
        end
        return (v <<< SH) >>> SH;
    endfunction

    t_cmd       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic       accept;
    logic       push;
    t_cmd       cmd_in;

    assign o_busy      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rd];
    assign accept      = i_start && !o_busy;

    always_comb begin
        cmd_in.x = f_coord(i_req.coord_x);
        cmd_in.y = f_coord(i_req.coord_y);
        push     = accept;
        unique case (i_req.req_type)
            REQ_CLEAR: cmd_in.kind = CMD_CLEAR;
            REQ_LOAD:  cmd_in.kind = CMD_LOAD;
            REQ_QUERY: cmd_in.kind = CMD_QUERY;
            default: begin
                // unused code: dropped here
                cmd_in.kind = CMD_CLEAR;
                push        = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end

endmodule

// File: design/nrt_back.sv
// Back end: executes clear/load/query, scans the table and emits tied matches.
module nrt_back
    import nrt_pkg::*;
#(
    parameter int MAX_REFS = 1024,
    parameter int MAX_TIES = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int IW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int CW = $clog2(MAX_REFS + 1);
    localparam int TA = (MAX_TIES > 1) ? $clog2(MAX_TIES) : 1;
    localparam int TC = $clog2(MAX_TIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state r_state;

    logic [CW-1:0]     r_ref_count;
    logic [QIDX_W-1:0] r_query_count;
    logic [QIDX_W-1:0] r_qnum;
    logic signed [PT_W-1:0] r_qx;
    logic signed [PT_W-1:0] r_qy;
    logic [IW-1:0]     r_scan_idx;

    // scan pipeline: read, abs diff, square, compare
    logic              r_v1, r_v2, r_v3;
    logic [IW-1:0]     r_i1, r_i2, r_i3;
    logic [ABS_W-1:0]  r_ax, r_ay;
    logic [SQ_W-1:0]   r_sx, r_sy;

    logic [DIST_W-1:0] r_best;
    logic [TC-1:0]     r_ties;
    logic              r_over;

    logic [TC-1:0]     r_emit_k;
    logic              r_out_vld;
    logic              r_out_last;

    // reference table
    logic              ref_we;
    logic [2*PT_W-1:0] ref_rdata;
    logic signed [PT_W-1:0] rx, ry;

    // tie list
    logic              tie_we;
    logic [TA-1:0]     tie_waddr;
    logic [IW-1:0]     tie_rdata;
    logic [RIDX_W+IW-1:0] tie_ext;

    logic signed [PT_W:0] dx, dy;
    logic [PT_W:0]     ax, ay;
    logic [DIST_W-1:0] dist_sum;
    logic              new_min;
    logic              tie_eq;
    logic              tie_room;
    logic              scan_last;
    logic              emit_last;

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign ref_we    = o_cmd_pop && (i_cmd.kind == CMD_LOAD) &&
                       (r_ref_count != CW'(MAX_REFS));

    nrt_ram #(
        .WIDTH (2 * PT_W),
        .DEPTH (MAX_REFS)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (r_ref_count[IW-1:0]),
        .i_wdata ({i_cmd.x, i_cmd.y}),
        .i_raddr (r_scan_idx),
        .o_rdata (ref_rdata)
    );

    nrt_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_TIES)
    ) u_tie_ram (
        .i_clk   (i_clk),
        .i_we    (tie_we),
        .i_waddr (tie_waddr),
        .i_wdata (r_i3),
        .i_raddr (r_emit_k[TA-1:0]),
        .o_rdata (tie_rdata)
    );

    always_comb begin
        rx = ref_rdata[2*PT_W-1:PT_W];
        ry = ref_rdata[PT_W-1:0];
        dx = {r_qx[PT_W-1], r_qx} - {rx[PT_W-1], rx};
        dy = {r_qy[PT_W-1], r_qy} - {ry[PT_W-1], ry};
        ax = dx[PT_W] ? (PT_W+1)'(-dx) : (PT_W+1)'(dx);
        ay = dy[PT_W] ? (PT_W+1)'(-dy) : (PT_W+1)'(dy);

        dist_sum  = {1'b0, r_sx} + {1'b0, r_sy};
        new_min   = r_v3 && ((r_i3 == '0) || (dist_sum < r_best));
        tie_eq    = r_v3 && !new_min && (dist_sum == r_best);
        tie_room  = (r_ties < TC'(MAX_TIES));
        tie_we    = new_min || (tie_eq && tie_room);
        tie_waddr = new_min ? '0 : r_ties[TA-1:0];

        scan_last = ((CW'(r_scan_idx) + CW'(1)) == r_ref_count);
        emit_last = ((r_emit_k + TC'(1)) == r_ties);

        tie_ext   = {{RIDX_W{1'b0}}, tie_rdata};
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.kind == CMD_QUERY)) begin
            r_qnum <= r_query_count;
            r_qx   <= i_cmd.x;
            r_qy   <= i_cmd.y;
        end
        r_i1 <= r_scan_idx;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_ax <= ax[ABS_W-1:0];
        r_ay <= ay[ABS_W-1:0];
        r_sx <= r_ax * r_ax;
        r_sy <= r_ay * r_ay;
        if (new_min) begin
            r_best <= dist_sum;
        end
        if (r_state == ST_EMIT) begin
            r_out_last <= emit_last;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_ref_count   <= '0;
            r_query_count <= '0;
            r_scan_idx    <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_ties        <= '0;
            r_over        <= 1'b0;
            r_emit_k      <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            r_v1      <= (r_state == ST_SCAN);
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_out_vld <= (r_state == ST_EMIT);

            if (new_min) begin
                r_ties <= TC'(1);
                r_over <= 1'b0;
            end else if (tie_eq) begin
                if (tie_room) begin
                    r_ties <= r_ties + TC'(1);
                end else begin
                    r_over <= 1'b1;
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        unique case (i_cmd.kind)
                            CMD_CLEAR: begin
                                r_ref_count   <= '0;
                                r_query_count <= '0;
                            end
                            CMD_LOAD: begin
                                if (ref_we) begin
                                    r_ref_count <= r_ref_count + CW'(1);
                                end
                            end
                            CMD_QUERY: begin
                                r_query_count <= r_query_count + QIDX_W'(1);
                                r_scan_idx    <= '0;
                                if (r_ref_count != '0) begin
                                    r_state <= ST_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (scan_last) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_scan_idx <= r_scan_idx + IW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!r_v1 && !r_v2 && !r_v3) begin
                        r_emit_k <= '0;
                        r_state  <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_emit_k <= r_emit_k + TC'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_strobe                 = r_out_vld;
    assign o_result.query_index     = r_qnum;
    assign o_result.ref_index       = tie_ext[RIDX_W-1:0];
    assign o_result.min_dist        = r_best;
    assign o_result.last_match      = r_out_last;
    assign o_result.tie_overflow    = r_over;

endmodule

// File: design/nearest_reference_with_ties_core.sv
// Top level: nearest reference point search with tie reporting.
// A query's result beats follow its start beat through the queue, the scan, the drain and the emit states.
// The back end takes no new command until a query's last result beat; clear and load stay in ST_IDLE.
// A two-entry command queue takes beats while a query runs; busy is high when it is full.
// Reset (synchronous, active low) empties table and queue, zeroes the query counter.
// No RAM clearing pass is needed; results cannot be stalled by the receiver.
module nearest_reference_with_ties_core
    import nrt_pkg::*;
#(
    parameter int MAX_REFS   = 1024,
    parameter int MAX_TIES   = 64,
    parameter int COORD_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    // Front: accepts the request beat, sign-extends coordinates from COORD_BITS to PT_W,
    // drops the unused request code and queues the command.
    nrt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: owns the reference table, the counters, the distance pipeline
    // (abs diff, square, compare) and the tie list, and drives the result beats.
    nrt_back #(
        .MAX_REFS (MAX_REFS),
        .MAX_TIES (MAX_TIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

// File: design/nrt_checker.sv
// Port-level checks for the nearest-reference core, bound to the top level.
`include "nearest_reference_with_ties_core_macros.svh"

module nrt_checker
    import nrt_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input t_req    i_req,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    // reset leaves no result beat pending and the queue open
    `NRT_ASSERT_AFTER_RST(a_rst_quiet, i_clk, i_rst_n, !o_strobe && !busy)

    // beats of one query come back to back with the same query number and distance
    `NRT_ASSERT_NEXT(a_burst_same_query, i_clk, i_rst_n, o_strobe && !o_result.last_match, o_strobe && $stable(o_result.query_index) && $stable(o_result.min_dist) && $stable(o_result.tie_overflow))

    // a new query needs a full scan, so no beat directly follows the last one
    `NRT_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_strobe && o_result.last_match, !o_strobe)

endmodule

bind nearest_reference_with_ties_core nrt_checker u_nrt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_req    (i_req),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// File: verif/nearest_match_checker.sv
// Checker for the nearest-reference block: predicts tied matches and compares result beats.
module nearest_match_checker
    import nrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int TIE_LIMIT   = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_req    i_req,
    input  logic    i_strobe,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending
);

    int                table_x [TABLE_DEPTH];
    int                table_y [TABLE_DEPTH];
    int                loaded_pts;
    logic [QIDX_W-1:0] query_seq;
    t_result           expected_matches [$];
    int                fails;

    initial begin
        loaded_pts   = 0;
        query_seq    = '0;
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic flag_failure(string what);
        fails++;
        if (fails <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Scan every loaded point, keep the least squared distance and the first
    // TIE_LIMIT indices that reach it; queue one expected beat per kept index.
    function automatic void predict_matches(int qx, int qy);
        longint  best;
        longint  dist_sq;
        longint  dx;
        longint  dy;
        int      tie_idx [$];
        logic    overflow;
        t_result m;
        int      i;
        best     = 0;
        overflow = 1'b0;
        for (i = 0; i < loaded_pts; i++) begin
            dx      = longint'(qx) - longint'(table_x[i]);
            dy      = longint'(qy) - longint'(table_y[i]);
            dist_sq = dx * dx + dy * dy;
            if (i == 0 || dist_sq < best) begin
                best     = dist_sq;
                overflow = 1'b0;
                tie_idx.delete();
            end
            if (dist_sq == best) begin
                if (tie_idx.size() < TIE_LIMIT) begin
                    tie_idx.push_back(i);
                end else begin
                    overflow = 1'b1;
                end
            end
        end
        foreach (tie_idx[k]) begin
            m.query_index  = query_seq;
            m.ref_index    = RIDX_W'(tie_idx[k]);
            m.min_dist     = DIST_W'(best);
            m.last_match   = (k == tie_idx.size() - 1);
            m.tie_overflow = overflow;
            expected_matches.push_back(m);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            loaded_pts = 0;
            query_seq  = '0;
            expected_matches.delete();
        end else begin
            if (i_strobe) begin
                if (expected_matches.size() == 0) begin
                    flag_failure($sformatf("result beat with nothing expected: %p", i_result));
                end else begin
                    want = expected_matches.pop_front();
                    if (i_result !== want) begin
                        flag_failure($sformatf(
                            "exp q=%0d ref=%0d dist=%0d last=%0b ovf=%0b, got q=%0d ref=%0d dist=%0d last=%0b ovf=%0b",
                            want.query_index, want.ref_index, want.min_dist,
                            want.last_match, want.tie_overflow,
                            i_result.query_index, i_result.ref_index, i_result.min_dist,
                            i_result.last_match, i_result.tie_overflow));
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_req.req_type)
                    REQ_CLEAR: begin
                        loaded_pts = 0;
                        query_seq  = '0;
                    end
                    REQ_LOAD: begin
                        if (loaded_pts < TABLE_DEPTH) begin
                            table_x[loaded_pts] = int'(i_req.coord_x);
                            table_y[loaded_pts] = int'(i_req.coord_y);
                            loaded_pts++;
                        end
                    end
                    REQ_QUERY: begin
                        predict_matches(int'(i_req.coord_x), int'(i_req.coord_y));
                        query_seq = query_seq + 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_matches.size();
        o_fail_count <= fails;
    end

endmodule

// File: verif/nearest_reference_with_ties_core_tb.sv
// Testbench top: request stimulus for the nearest-reference block, watchdog and verdict.
module nearest_reference_with_ties_core_tb;
    import nrt_pkg::*;

    // The fourth request code has no name in the package; the block ignores it.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int TABLE_DEPTH  = 1024;
    localparam int TIE_LIMIT    = 64;
    // A quiet spell several times longer than a full-table scan is a hang.
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 200;
    localparam int RANDOM_BEATS = 150;

    localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;
    localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7fff;

    // How random coordinates are spread: tight clusters give many ties,
    // edges give the extreme distances.
    typedef enum int {
        SPREAD_WIDE  = 0,
        SPREAD_TIGHT = 1,
        SPREAD_EDGES = 2
    } t_spread;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_req    i_req;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    int fail_count;
    int pending;
    int idle_pct     = 25;
    int beats_sent   = 0;
    int quiet_cycles = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    nearest_reference_with_ties_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    nearest_match_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIE_LIMIT   (TIE_LIMIT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: any accepted beat, in or out, counts as progress.
    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_strobe)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [COORD_W-1:0] pick_coord(t_spread spread);
        int v;
        v = 0;
        case (spread)
            SPREAD_WIDE:  pick_coord = COORD_W'($urandom);
            SPREAD_TIGHT: begin
                v          = $urandom_range(8);
                pick_coord = COORD_W'(v - 4);
            end
            default: begin
                case ($urandom_range(3))
                    0:       pick_coord = C_MIN;
                    1:       pick_coord = C_MAX;
                    2:       pick_coord = '0;
                    default: pick_coord = '1;
                endcase
            end
        endcase
    endfunction

    // One request beat: optional idle cycles at the falling edge, then hold
    // start until a rising edge sees busy low. Only one assignment to start
    // per falling edge, so back-to-back beats keep start high.
    task automatic send_beat(logic [REQ_W-1:0] kind,
                             logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= '{kind, x, y};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (kind != REQ_UNUSED) beats_sent++;
    endtask

    initial begin
        t_spread                   spread;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        int                        n_pts;
        int                        n_q;
        int                        phase_base;
        int                        phase;

        start   = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed beats ----
        // query on an empty table: no result, but the query number moves on
        send_beat(REQ_QUERY, '0, '0);
        // unused request code, all coordinate bits set: ignored
        send_beat(REQ_UNUSED, '1, '1);
        send_beat(REQ_LOAD, C_MIN, C_MIN);
        send_beat(REQ_LOAD, C_MAX, C_MAX);
        send_beat(REQ_LOAD, '0, '0);
        send_beat(REQ_LOAD, C_MIN, C_MIN);
        // exact hit on one point
        send_beat(REQ_QUERY, C_MAX, C_MAX);
        // two identical points tie at distance zero
        send_beat(REQ_QUERY, C_MIN, C_MIN);
        // four-way tie at distance one around the origin
        send_beat(REQ_CLEAR, '0, '0);
        send_beat(REQ_LOAD, 16'sd0, 16'sd1);
        send_beat(REQ_LOAD, 16'sd0, -16'sd1);
        send_beat(REQ_LOAD, 16'sd1, 16'sd0);
        send_beat(REQ_LOAD, -16'sd1, 16'sd0);
        send_beat(REQ_QUERY, '0, '0);
        // largest distance: opposite corners
        send_beat(REQ_CLEAR, C_MAX, C_MIN);
        send_beat(REQ_QUERY, C_MAX, C_MAX);
        send_beat(REQ_LOAD, C_MIN, C_MIN);
        send_beat(REQ_QUERY, C_MAX, C_MAX);
        send_beat(REQ_LOAD, C_MAX, C_MIN);
        send_beat(REQ_QUERY, C_MIN, C_MAX);

        // ---- tie limit: exactly TIE_LIMIT ties, then one more ----
        px = pick_coord(SPREAD_WIDE);
        py = pick_coord(SPREAD_WIDE);
        send_beat(REQ_CLEAR, '0, '0);
        repeat (3) send_beat(REQ_LOAD, pick_coord(SPREAD_WIDE), pick_coord(SPREAD_WIDE));
        repeat (TIE_LIMIT) send_beat(REQ_LOAD, px, py);
        send_beat(REQ_QUERY, px, py);
        send_beat(REQ_LOAD, px, py);
        send_beat(REQ_QUERY, px, py);
        send_beat(REQ_QUERY, pick_coord(SPREAD_WIDE), pick_coord(SPREAD_WIDE));
        send_beat(REQ_CLEAR, '0, '0);

        // ---- random part in three idling phases: 25%, 74%, none ----
        for (phase = 0; phase < 3; phase++) begin
            idle_pct   = (phase == 0) ? 25 : (phase == 1) ? 74 : 0;
            phase_base = beats_sent;
            while (beats_sent - phase_base < RANDOM_BEATS / 3) begin
                if ($urandom_range(9) == 0) begin
                    // noise: any code, any coordinates
                    send_beat(REQ_W'($urandom_range(3)), COORD_W'($urandom), COORD_W'($urandom));
                end else begin
                    // well-formed run: maybe clear, a few loads, a few queries
                    spread = t_spread'($urandom_range(2));
                    if ($urandom_range(2) == 0) begin
                        send_beat(REQ_CLEAR, pick_coord(spread), pick_coord(spread));
                    end
                    n_pts = $urandom_range(8);
                    repeat (n_pts) send_beat(REQ_LOAD, pick_coord(spread), pick_coord(spread));
                    n_q = $urandom_range(1, 3);
                    repeat (n_q) send_beat(REQ_QUERY, pick_coord(spread), pick_coord(spread));
                end
            end
        end

        @(negedge i_clk);
        start <= 1'b0;

        // wait for every expected match, then let any trailing scan finish
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
